// ===== hw/rtl/pid_with_antiwindup_core_assert.svh =====
// Assertion macros for the PID regulator core.
// Included by the top level; no other dependencies.
`ifndef PID_WITH_ANTIWINDUP_CORE_ASSERT_SVH
`define PID_WITH_ANTIWINDUP_CORE_ASSERT_SVH

// Checked outside reset only
`ifndef SYNTH
`define PIDAW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pidaw assertion failed");
`else
`define PIDAW_ASSERT(lbl, prop)
`endif

// Checked on every edge, reset included
`ifndef SYNTH
`define PIDAW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pidaw assertion failed");
`else
`define PIDAW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/pidaw_pkg.sv =====
// Shared types and constants for the PID regulator core.
// Used by the microcode table, sequencer, datapath and top level.
package pidaw_pkg;

  // Configuration register layout
  localparam int REG_W   = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE      = 3'd6;

  localparam logic [REG_W-1:0] RST_PROP_GAIN      = 31'd26214400;
  localparam logic [REG_W-1:0] RST_INTEG_GAIN     = 31'd327680;
  localparam logic [REG_W-1:0] RST_DERIV_GAIN     = 31'd1310720;
  localparam logic [REG_W-1:0] RST_OUTPUT_LIMIT   = 31'd98304000;
  localparam logic [REG_W-1:0] RST_INTEGRAL_LIMIT = 31'd19660800;
  localparam logic [REG_W-1:0] RST_STEP_TIME      = 31'd3277;
  localparam logic [REG_W-1:0] RST_STEP_RATE      = 31'd1310720;

  // Input word opcodes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] prop_gain;
    logic [REG_W-1:0] integ_gain;
    logic [REG_W-1:0] deriv_gain;
    logic [REG_W-1:0] output_limit;
    logic [REG_W-1:0] integral_limit;
    logic [REG_W-1:0] step_time;
    logic [REG_W-1:0] step_rate;
  } cfg_t;

  // Microprogram addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ERR   = 4'd0;
  localparam step_t STEP_MUL_T = 4'd1;
  localparam step_t STEP_INTEG = 4'd2;
  localparam step_t STEP_DERIV = 4'd3;
  localparam step_t STEP_P     = 4'd4;
  localparam step_t STEP_I     = 4'd5;
  localparam step_t STEP_D     = 4'd6;
  localparam step_t STEP_OUT   = 4'd7;
  localparam step_t STEP_CLEAR = 4'd8;

  // Control word fields
  typedef enum logic [1:0] {MA_ERR, MA_DIFF, MA_INTEG, MA_DER} mula_t;
  typedef enum logic [2:0] {MB_STIME, MB_SRATE, MB_KP, MB_KI, MB_KD} mulb_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_t;
  typedef enum logic [1:0] {OUT_NONE, OUT_ACC, OUT_ZERO} outsel_t;

  typedef struct packed {
    mula_t   mul_a;
    mulb_t   mul_b;
    logic    mul_en;
    acc_t    acc_op;
    logic    ld_err;
    logic    ld_integ;
    logic    ld_der;
    logic    ld_prev;
    logic    clr_state;
    outsel_t out_sel;
    logic    br_op;
    step_t   br_target;
  } ctrl_t;

  // Sequencer to datapath strobes
  typedef struct packed {
    logic accept;
    logic adv;
  } seq_ctl_t;

endpackage

// ===== hw/rtl/pid_with_antiwindup_core.sv =====
// PID regulator core with integrator clamp, signed Q16.16.
// A compute word runs the whole microcode program; a clear word branches from
// the error step to the clear step. Each emits one result, and the next word
// is taken after it. The single shared multiplier forms at most one product a step.
// Reset (synchronous) empties the sequencer, zeroes the integral and previous
// error, and loads the register defaults.
module pid_with_antiwindup_core import pidaw_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic signed [31:0]   reference,
  input  logic signed [31:0]   measurement,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   drive,
  output logic                 clamped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

`include "pid_with_antiwindup_core_assert.svh"

  cfg_t     cfg;
  ctrl_t    ctrl;
  step_t    step;
  seq_ctl_t sctl;

  assign cfg_ready = 1'b1;

  // Register file; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= RST_PROP_GAIN;
      cfg.integ_gain     <= RST_INTEG_GAIN;
      cfg.deriv_gain     <= RST_DERIV_GAIN;
      cfg.output_limit   <= RST_OUTPUT_LIMIT;
      cfg.integral_limit <= RST_INTEGRAL_LIMIT;
      cfg.step_time      <= RST_STEP_TIME;
      cfg.step_rate      <= RST_STEP_RATE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data;
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data;
        REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data;
        REG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data;
        REG_STEP_TIME:      cfg.step_time      <= cfg_data;
        REG_STEP_RATE:      cfg.step_rate      <= cfg_data;
        default:            cfg <= cfg;
      endcase
    end
  end

  pidaw_ucode u_ucode (
    .step (step),
    .ctrl (ctrl)
  );

  pidaw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .step      (step),
    .sctl      (sctl)
  );

  pidaw_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .reference   (reference),
    .measurement (measurement),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .sctl        (sctl),
    .drive       (drive),
    .clamped     (clamped)
  );

  // Results only come from a word in progress
  `PIDAW_ASSERT(a_result_needs_work, $rose(out_valid) |-> $past(in_stall))
  // A result step with a free output register always delivers
  `PIDAW_ASSERT(a_result_step_emits,
    (in_stall && !out_valid && ctrl.out_sel != OUT_NONE) |=> out_valid)
  // Reset leaves the core idle with no pending result
  `PIDAW_ASSERT_ALWAYS(a_reset_idle, rst |=> (!in_stall && !out_valid))

endmodule

// ===== hw/rtl/pidaw_ucode.sv =====
// Microprogram table of the PID regulator core: one control word per step.
// Depends on pidaw_pkg.
module pidaw_ucode import pidaw_pkg::*; (
  input  step_t step,
  output ctrl_t ctrl
);

  // Decode step address to control word
  always_comb begin
    ctrl = '{mul_a: MA_ERR, mul_b: MB_STIME, mul_en: 1'b0, acc_op: ACC_HOLD,
             ld_err: 1'b0, ld_integ: 1'b0, ld_der: 1'b0, ld_prev: 1'b0,
             clr_state: 1'b0, out_sel: OUT_NONE, br_op: 1'b0,
             br_target: STEP_ERR};
    unique case (step)
      STEP_ERR: begin
        ctrl.ld_err    = 1'b1;
        ctrl.br_op     = 1'b1;
        ctrl.br_target = STEP_CLEAR;
      end
      STEP_MUL_T: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = MA_ERR;
        ctrl.mul_b  = MB_STIME;
      end
      STEP_INTEG: begin
        ctrl.ld_integ = 1'b1;
        ctrl.mul_en   = 1'b1;
        ctrl.mul_a    = MA_DIFF;
        ctrl.mul_b    = MB_SRATE;
      end
      STEP_DERIV: begin
        ctrl.ld_der  = 1'b1;
        ctrl.ld_prev = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_a   = MA_ERR;
        ctrl.mul_b   = MB_KP;
      end
      STEP_P: begin
        ctrl.acc_op = ACC_LOAD;
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = MA_INTEG;
        ctrl.mul_b  = MB_KI;
      end
      STEP_I: begin
        ctrl.acc_op = ACC_ADD;
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = MA_DER;
        ctrl.mul_b  = MB_KD;
      end
      STEP_D: begin
        ctrl.acc_op = ACC_ADD;
      end
      STEP_OUT: begin
        ctrl.out_sel = OUT_ACC;
      end
      STEP_CLEAR: begin
        ctrl.clr_state = 1'b1;
        ctrl.out_sel   = OUT_ZERO;
      end
      default: begin
        ctrl.out_sel = OUT_NONE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pidaw_seq.sv =====
// Step counter and handshake control of the PID regulator core.
// Depends on pidaw_pkg; reads the control word from pidaw_ucode.
module pidaw_seq import pidaw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     op,
  input  logic     out_stall,
  input  ctrl_t    ctrl,
  output logic     in_stall,
  output logic     out_valid,
  output step_t    step,
  output seq_ctl_t sctl
);

  logic busy;
  logic op_r;
  logic emit;
  logic out_free;

  assign emit        = (ctrl.out_sel != OUT_NONE);
  assign out_free    = !out_valid || !out_stall;
  assign sctl.accept = in_valid && !busy;
  // Hold on a result step until the output register is free
  assign sctl.adv    = busy && (!emit || out_free);
  assign in_stall    = busy;

  // Advance the program, branch on clear, release on result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= STEP_ERR;
    end else begin
      // Raise on a result step, drop once the word is taken
      if (sctl.adv && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (sctl.accept) begin
        busy <= 1'b1;
        step <= STEP_ERR;
      end else if (sctl.adv) begin
        if (emit) begin
          busy <= 1'b0;
        end else if (ctrl.br_op && (op_r == OP_CLEAR)) begin
          step <= ctrl.br_target;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  // Capture the opcode of the accepted word
  always_ff @(posedge clk) begin
    if (sctl.accept) begin
      op_r <= op;
    end
  end

endmodule

// ===== hw/rtl/pidaw_dp.sv =====
// Datapath of the PID regulator core: one shared multiplier, accumulator,
// saturation and clamp logic. Depends on pidaw_pkg; driven by the microcode.
module pidaw_dp import pidaw_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] reference,
  input  logic signed [31:0] measurement,
  input  cfg_t               cfg,
  input  ctrl_t              ctrl,
  input  seq_ctl_t           sctl,
  output logic signed [31:0] drive,
  output logic               clamped
);

  localparam int WORK_BITS = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (WORK_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  logic signed [31:0] ref_r, meas_r;
  logic signed [31:0] err_r, prev_r, integ_r, der_r;
  logic signed [63:0] prod_r, acc_r;

  logic signed [32:0] in_diff;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_full;
  logic signed [63:0] prod_sh;
  logic signed [63:0] isum_raw, ilim, olim;
  logic signed [31:0] isum_clamp, err_sat, der_sat;
  logic signed [31:0] drive_next;
  logic               clamped_next;

  // Saturate to the working width, keep 32 bits
  function automatic logic signed [31:0] sat_work(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end
    return y[31:0];
  endfunction

  // Error of the captured word
  assign in_diff = {ref_r[31], ref_r} - {meas_r[31], meas_r};
  assign err_sat = sat_work({{31{in_diff[32]}}, in_diff});

  // Multiplier operand select
  always_comb begin
    case (ctrl.mul_a)
      MA_ERR:   mul_a = {err_r[31], err_r};
      MA_DIFF:  mul_a = {err_r[31], err_r} - {prev_r[31], prev_r};
      MA_INTEG: mul_a = {integ_r[31], integ_r};
      MA_DER:   mul_a = {der_r[31], der_r};
      default:  mul_a = '0;
    endcase
    case (ctrl.mul_b)
      MB_STIME: mul_b = {1'b0, cfg.step_time};
      MB_SRATE: mul_b = {1'b0, cfg.step_rate};
      MB_KP:    mul_b = {1'b0, cfg.prop_gain};
      MB_KI:    mul_b = {1'b0, cfg.integ_gain};
      MB_KD:    mul_b = {1'b0, cfg.deriv_gain};
      default:  mul_b = '0;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  // Arithmetic shift rounds toward minus infinity
  assign prod_sh  = prod_r >>> FRAC_BITS;
  assign der_sat  = sat_work(prod_sh);

  // Integral update with clamp to the integral limit
  assign ilim     = {33'd0, cfg.integral_limit};
  assign isum_raw = {{32{integ_r[31]}}, integ_r} + prod_sh;
  always_comb begin
    isum_clamp = isum_raw[31:0];
    if (isum_raw > ilim) begin
      isum_clamp = ilim[31:0];
    end else if (isum_raw < -ilim) begin
      isum_clamp = -ilim[31:0];
    end
  end

  // Output clamp
  assign olim = {33'd0, cfg.output_limit};
  always_comb begin
    drive_next   = acc_r[31:0];
    clamped_next = 1'b0;
    if (acc_r > olim) begin
      drive_next   = olim[31:0];
      clamped_next = 1'b1;
    end else if (acc_r < -olim) begin
      drive_next   = -olim[31:0];
      clamped_next = 1'b1;
    end
  end

  // Controller state: integral and previous error
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (sctl.adv) begin
      if (ctrl.clr_state) begin
        integ_r <= '0;
        prev_r  <= '0;
      end else begin
        if (ctrl.ld_integ) begin
          integ_r <= isum_clamp;
        end
        if (ctrl.ld_prev) begin
          prev_r <= err_r;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (sctl.accept) begin
      ref_r  <= reference;
      meas_r <= measurement;
    end
    if (sctl.adv) begin
      if (ctrl.ld_err) begin
        err_r <= err_sat;
      end
      if (ctrl.ld_der) begin
        der_r <= der_sat;
      end
      if (ctrl.mul_en) begin
        prod_r <= mul_full[63:0];
      end
      case (ctrl.acc_op)
        ACC_LOAD: acc_r <= prod_sh;
        ACC_ADD:  acc_r <= acc_r + prod_sh;
        default:  acc_r <= acc_r;
      endcase
      case (ctrl.out_sel)
        OUT_ACC: begin
          drive   <= drive_next;
          clamped <= clamped_next;
        end
        OUT_ZERO: begin
          drive   <= '0;
          clamped <= 1'b0;
        end
        default: begin
          drive   <= drive;
          clamped <= clamped;
        end
      endcase
    end
  end

endmodule

// ===== tb/pid_with_antiwindup_core_tb.sv =====
// Self-checking testbench for the PID regulator core with integrator clamp.
// Drives control and clear words with random idling on both sides and predicts
// every drive word. Depends on pidaw_pkg and pid_with_antiwindup_core.
module pid_with_antiwindup_core_tb;
  import pidaw_pkg::*;

  localparam int WORK_W = 32;
  localparam int FRAC_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [REG_W-1:0]     REG_MAX    = {REG_W{1'b1}};

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  localparam logic signed [31:0] Q_1000 = 32'sd65536000;
  localparam logic signed [31:0] S_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN  = 32'sh8000_0000;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 16;

  typedef struct {
    logic               op;
    logic signed [31:0] reference;
    logic signed [31:0] measurement;
  } pid_word_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               clamped;
  } pid_out_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 op          = OP_COMPUTE;
  logic signed [31:0]   reference   = '0;
  logic signed [31:0]   measurement = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic signed [31:0]   drive;
  logic                 clamped;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [REG_W-1:0]     cfg_data    = '0;

  // Words waiting to be offered, and drive words the regulator owes
  pid_word_t step_words[$];
  pid_out_t  expected_drive[$];

  // Regulator settings and state as the checker sees them
  longint kp_q, ki_q, kd_q, out_lim_q, integ_lim_q, dt_q, rate_q;
  longint integ_acc, prev_err;

  bit          in_taken  = 1'b0;
  bit          out_taken = 1'b0;
  int          idle_mode = 0;
  int          tx_wait   = 0;
  int          rx_wait   = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          errors    = 0;
  int unsigned cycles    = 0;

  pid_with_antiwindup_core #(
    .DATA_WIDTH(WORK_W),
    .FRAC_BITS (FRAC_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .reference  (reference),
    .measurement(measurement),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive      (drive),
    .clamped    (clamped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Saturate to a signed working-width value
  function automatic longint sat_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // Exact Q16.16 product, floored back to Q16.16
  function automatic longint fx_mul(input longint a, input longint g);
    return (a * g) >>> FRAC_W;
  endfunction

  // Advance the regulator state by one word and return its drive word
  function automatic pid_out_t control_step(input pid_word_t w);
    pid_out_t r;
    longint   err, isum, der, sum;
    r.drive   = '0;
    r.clamped = 1'b0;
    if (w.op == OP_CLEAR) begin
      integ_acc = 0;
      prev_err  = 0;
      return r;
    end
    err  = sat_word(longint'(w.reference) - longint'(w.measurement));
    isum = integ_acc + fx_mul(err, dt_q);
    if (isum > integ_lim_q) isum = integ_lim_q;
    if (isum < -integ_lim_q) isum = -integ_lim_q;
    integ_acc = isum;
    der      = sat_word(fx_mul(err - prev_err, rate_q));
    prev_err = err;
    sum = fx_mul(err, kp_q) + fx_mul(isum, ki_q) + fx_mul(der, kd_q);
    if (sum > out_lim_q) begin
      sum       = out_lim_q;
      r.clamped = 1'b1;
    end
    if (sum < -out_lim_q) begin
      sum       = -out_lim_q;
      r.clamped = 1'b1;
    end
    r.drive = sum[31:0];
    return r;
  endfunction

  // Idle cycles before the next word on either side
  function automatic int idle_draw();
    case (idle_mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // Mostly operating-point errors, some full-range words, a few clears
  function automatic pid_word_t rand_word();
    pid_word_t   w;
    int unsigned pick;
    pick          = $urandom_range(0, 15);
    w.op          = (pick == 0) ? OP_CLEAR : OP_COMPUTE;
    w.reference   = $urandom;
    w.measurement = $urandom;
    if (pick >= 4) begin
      w.reference   = w.reference >>> $urandom_range(6, 14);
      w.measurement = w.reference + (w.measurement >>> $urandom_range(10, 24));
    end
    return w;
  endfunction

  function automatic logic [REG_W-1:0] rand_reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return REG_MAX;
      2, 3, 4: return REG_W'($urandom_range(0, 32'h0100_0000));
      default: return REG_W'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic o, input logic signed [31:0] r,
                           input logic signed [31:0] m);
    pid_word_t w;
    w.op          = o;
    w.reference   = r;
    w.measurement = m;
    step_words.insert(step_words.size(), w);
  endtask

  // Wait until every word is taken and answered, then let the core settle
  task automatic drain();
    while (step_words.size() != 0 || in_valid || expected_drive.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [REG_W-1:0] kp, ki, kd, olim, ilim, dt, rate);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_OUTPUT_LIMIT, olim);
    write_reg(REG_INTEGRAL_LIMIT, ilim);
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_STEP_RATE, rate);
  endtask

  task automatic load_random_regs();
    load_regs(rand_reg_value(), rand_reg_value(), rand_reg_value(), rand_reg_value(),
              rand_reg_value(), rand_reg_value(), rand_reg_value());
    if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, REG_W'($urandom));
  endtask

  task automatic run_random(input int n);
    repeat (n) step_words.insert(step_words.size(), rand_word());
    drain();
  endtask

  // Monitor: track settings, predict taken words, check drive words
  always @(posedge clk) begin
    pid_word_t w;
    pid_out_t  want;
    if (rst) begin
      kp_q        = RST_PROP_GAIN;
      ki_q        = RST_INTEG_GAIN;
      kd_q        = RST_DERIV_GAIN;
      out_lim_q   = RST_OUTPUT_LIMIT;
      integ_lim_q = RST_INTEGRAL_LIMIT;
      dt_q        = RST_STEP_TIME;
      rate_q      = RST_STEP_RATE;
      integ_acc   = 0;
      prev_err    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:      kp_q        = cfg_data;
          REG_INTEG_GAIN:     ki_q        = cfg_data;
          REG_DERIV_GAIN:     kd_q        = cfg_data;
          REG_OUTPUT_LIMIT:   out_lim_q   = cfg_data;
          REG_INTEGRAL_LIMIT: integ_lim_q = cfg_data;
          REG_STEP_TIME:      dt_q        = cfg_data;
          REG_STEP_RATE:      rate_q      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        w.op          = op;
        w.reference   = reference;
        w.measurement = measurement;
        expected_drive.insert(expected_drive.size(), control_step(w));
      end
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          $error("drive: no word expected, got %0d", drive);
          errors++;
        end else begin
          want = expected_drive[0];
          expected_drive.delete(0);
          if (drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, drive);
            errors++;
          end
          if (clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, clamped);
            errors++;
          end
        end
      end
    end
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
  end

  // Driver: offer queued words after the drawn idle gap
  always @(negedge clk) begin
    pid_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (in_valid && !in_taken) begin
      // hold the word until it is taken
    end else if (tx_wait > 0) begin
      tx_wait--;
      in_valid <= 1'b0;
    end else if (step_words.size() > 0) begin
      w = step_words[0];
      step_words.delete(0);
      op          <= w.op;
      reference   <= w.reference;
      measurement <= w.measurement;
      in_valid    <= 1'b1;
      tx_wait = idle_draw();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall for a drawn gap after each drive word, or hold off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (out_taken) rx_wait = idle_draw();
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings: extremes, saturation, clears, windup
    idle_mode = 2;
    push_word(OP_COMPUTE, '0, '0);
    push_word(OP_COMPUTE, Q_ONE, '0);
    push_word(OP_COMPUTE, '0, Q_ONE);
    push_word(OP_COMPUTE, S_MAX, S_MIN);
    push_word(OP_COMPUTE, S_MAX, S_MIN);
    push_word(OP_COMPUTE, S_MIN, S_MAX);
    push_word(OP_COMPUTE, S_MAX, S_MAX);
    push_word(OP_CLEAR, $urandom, $urandom);
    push_word(OP_COMPUTE, S_MIN, '0);
    push_word(OP_COMPUTE, S_MAX, -32'sd1);
    push_word(OP_COMPUTE, -32'sd1, S_MAX);
    push_word(OP_CLEAR, S_MIN, S_MAX);
    push_word(OP_COMPUTE, Q_ONE, Q_ONE >>> 1);
    repeat (8) push_word(OP_COMPUTE, Q_1000, '0);
    repeat (3) push_word(OP_COMPUTE, -Q_1000, '0);
    push_word(OP_CLEAR, '1, '1);
    drain();

    // Modest gains, smallest nonzero step time, and a write to an unused index
    load_regs(31'd65536, 31'd32768, 31'd16384, 31'd6553600, 31'd655360, 31'd1, 31'd65536);
    write_reg(REG_UNUSED, REG_W'($urandom));
    idle_mode = 1;
    run_random(300);

    // Every register at its top value
    load_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    idle_mode = 0;
    run_random(150);

    // Zero limits and zero step scaling
    load_regs(rand_reg_value(), rand_reg_value(), rand_reg_value(), '0, '0, '0, '0);
    idle_mode = 2;
    run_random(120);

    // Hold off the output long enough to back up the input
    load_random_regs();
    idle_mode = 0;
    hold_reqs++;
    run_random(60);

    // Random settings with rotating idle patterns
    for (int k = 0; k < 6; k++) begin
      load_random_regs();
      idle_mode = k % 3;
      run_random(130);
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_ucode.sv
hw/rtl/pidaw_seq.sv
hw/rtl/pidaw_dp.sv
hw/rtl/pid_with_antiwindup_core.sv
tb/pid_with_antiwindup_core_tb.sv
